// ===== src/dspm_pkg.sv =====
package dspm_pkg;

   // Token store capacity and derived widths
   localparam int MAX_TOKENS = 32;
   localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
   localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

   // Pattern metacharacters
   localparam logic [7:0] DOT_BYTE  = 8'h2E;
   localparam logic [7:0] STAR_BYTE = 8'h2A;

   // Request beat kinds
   typedef enum logic [1:0] {
      MODE_PATTERN = 2'd0,
      MODE_TEXT    = 2'd1,
      MODE_END     = 2'd2,
      MODE_CLEAR   = 2'd3
   } dspm_mode_type;

   // Broadcast to every cell
   typedef struct packed {
      logic       restart;
      logic       text;
      logic [7:0] byte_value;
   } dspm_bcast_type;

   // Per-cell selects from the token bookkeeping
   typedef struct packed {
      logic write_tok;
      logic set_star;
      logic in_range;
   } dspm_sel_type;

endpackage

// ===== src/dspm_if.sv =====
interface dspm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] byte_value;

   modport source  (output valid, output mode, output byte_value, input ready);
   modport sink    (input valid, input mode, input byte_value, output ready);
   modport monitor (input valid, input mode, input byte_value, input ready);
endinterface

interface dspm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic pattern_overflow;

   modport source  (output valid, output matched, output pattern_overflow, input ready);
   modport sink    (input valid, input matched, input pattern_overflow, output ready);
   modport monitor (input valid, input matched, input pattern_overflow, input ready);
endinterface

// ===== src/dspm_cell.sv =====
module dspm_cell (
   input  logic                     clock,
   input  dspm_pkg::dspm_bcast_type bcast,
   input  dspm_pkg::dspm_sel_type   sel,
   input  logic                     restart_value,
   input  logic                     carry_in,
   input  logic                     shift_in,
   output logic                     carry_out,
   output logic                     shift_out,
   output logic                     closed,
   output logic                     starred
);
   import dspm_pkg::*;

   logic [7:0] byte_ff;
   logic       starred_ff;
   logic       active_ff;
   logic       active_in;
   logic       hit;

   // Closure: an active starred token also activates the next position
   assign closed    = active_ff | carry_in;
   assign carry_out = closed & starred_ff & sel.in_range;

   // Byte compare against this token
   assign hit = sel.in_range & closed &
                ((byte_ff == bcast.byte_value) || (byte_ff == DOT_BYTE));

   // Unstarred hit advances to the neighbor; starred hit stays here
   assign shift_out = hit & ~starred_ff;
   assign starred   = starred_ff;

   always_comb begin
      active_in = active_ff;
      if (bcast.restart) begin
         active_in = restart_value;
      end else if (bcast.text) begin
         active_in = (hit & starred_ff) | shift_in;
      end
   end

   always_ff @(posedge clock) begin
      active_ff <= active_in;
      if (sel.write_tok) begin
         byte_ff    <= bcast.byte_value;
         starred_ff <= 1'b0;
      end else if (sel.set_star) begin
         starred_ff <= 1'b1;
      end
   end

endmodule

// ===== src/dot_star_pattern_matcher.sv =====
// An end-of-text beat shows its result on rsp_chan in the cycle after acceptance.
// Throughput: one request beat per cycle; the row of position cells advances the
// active set and ripples the star closure within that cycle.
// Requests stall only while a result waits on rsp_chan and is not taken.
// Reset (synchronous): empty pattern, overflow clear, only position zero active.
module dot_star_pattern_matcher (
   input logic clock,
   input logic reset,
   dspm_req_if.sink   req_chan,
   dspm_rsp_if.source rsp_chan
);
   import dspm_pkg::*;

   logic [CNT_W-1:0]    total_ff, total_in;
   logic                overflow_ff, overflow_in;
   logic                final_active_ff, final_active_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_matched_ff, rsp_matched_in;
   logic                rsp_overflow_ff, rsp_overflow_in;

   dspm_mode_type       mode;
   logic                accept;
   logic                load;
   logic                star_hit;
   logic [IDX_W-1:0]    last_idx;
   logic [CNT_W-1:0]    total_dec;
   logic                hit_final;
   dspm_bcast_type      bcast;
   dspm_sel_type        sel      [MAX_TOKENS];
   logic [MAX_TOKENS:0] carry;
   logic [MAX_TOKENS:0] shift;
   logic [MAX_TOKENS:0] closed_vec;
   logic [MAX_TOKENS-1:0] starred_vec;

   // Handshake
   assign mode           = dspm_mode_type'(req_chan.mode);
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   // Pattern tokenizing
   assign total_dec = total_ff - CNT_W'(1);
   assign last_idx  = total_dec[IDX_W-1:0];
   assign load      = accept & (mode == MODE_PATTERN) & ~overflow_ff;
   assign star_hit  = (req_chan.byte_value == STAR_BYTE) && (total_ff != '0) &&
                      !starred_vec[last_idx];

   assign bcast.restart    = reset | (accept & ((mode == MODE_END) || (mode == MODE_CLEAR)));
   assign bcast.text       = accept & (mode == MODE_TEXT);
   assign bcast.byte_value = req_chan.byte_value;

   assign carry[0] = 1'b0;
   assign shift[0] = 1'b0;

   // Row of position cells
   for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
      assign sel[i].in_range  = CNT_W'(i) < total_ff;
      assign sel[i].write_tok = load & ~star_hit & (total_ff < CNT_W'(MAX_TOKENS)) &
                                (total_ff == CNT_W'(i));
      assign sel[i].set_star  = load & star_hit & (last_idx == IDX_W'(i));

      dspm_cell u_cell (
         .clock         (clock),
         .bcast         (bcast),
         .sel           (sel[i]),
         .restart_value ((i == 0) ? 1'b1 : 1'b0),
         .carry_in      (carry[i]),
         .shift_in      (shift[i]),
         .carry_out     (carry[i+1]),
         .shift_out     (shift[i+1]),
         .closed        (closed_vec[i]),
         .starred       (starred_vec[i])
      );
   end

   // Final position past the last cell
   assign closed_vec[MAX_TOKENS] = final_active_ff | carry[MAX_TOKENS];
   assign hit_final              = closed_vec[total_ff];

   always_comb begin
      total_in        = total_ff;
      overflow_in     = overflow_ff;
      final_active_in = final_active_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;

      if (load && !star_hit) begin
         if (total_ff >= CNT_W'(MAX_TOKENS)) begin
            overflow_in = 1'b1;
         end else begin
            total_in = total_ff + CNT_W'(1);
         end
      end
      if (accept && (mode == MODE_CLEAR)) begin
         total_in    = '0;
         overflow_in = 1'b0;
      end

      if (bcast.restart) begin
         final_active_in = 1'b0;
      end else if (bcast.text) begin
         final_active_in = shift[MAX_TOKENS];
      end

      // Result register
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && (mode == MODE_END)) begin
         rsp_valid_in    = 1'b1;
         rsp_matched_in  = hit_final & ~overflow_ff;
         rsp_overflow_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff        <= '0;
         overflow_ff     <= 1'b0;
         final_active_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         total_ff        <= total_in;
         overflow_ff     <= overflow_in;
         final_active_ff <= final_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.matched          = rsp_matched_ff;
   assign rsp_chan.pattern_overflow = rsp_overflow_ff;

endmodule

// ===== src/dspm_checker.sv =====
module dspm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_matched,
   input logic       rsp_pattern_overflow
);
   import dspm_pkg::*;

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_valid & req_ready;
   assign rsp_beat = rsp_valid & rsp_ready;

   // A waiting result is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before taken");

   // Every end-of-text beat gives a result next cycle
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_mode == MODE_END) |=> rsp_valid)
      else $error("end-of-text beat gave no result");

   // Other beats create no result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat || !rsp_valid) && !(req_beat && (req_mode == MODE_END))
      |=> !rsp_valid)
      else $error("result without end-of-text beat");

   // Overflow forces no match
   a_ovf_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_overflow |-> !rsp_matched)
      else $error("match reported with pattern overflow");

endmodule

bind dot_star_pattern_matcher dspm_checker u_dspm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .req_mode             (req_chan.mode),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_matched          (rsp_chan.matched),
   .rsp_pattern_overflow (rsp_chan.pattern_overflow)
);
